/* rtl/box_collision_table_defines.svh */
// assertion macros for the box collision table rtl
// no dependencies
`ifndef BOX_COLLISION_TABLE_DEFINES_SVH
`define BOX_COLLISION_TABLE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define BCT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bct assertion failed");

// implication with the consequent checked in the cycle after the antecedent
`define BCT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bct assertion failed");

`endif

/* rtl/bct_pkg.sv */
// types, codes and the overlap test for the box collision table
// no dependencies
`default_nettype none
package bct_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int MAX_HITS     = 32;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [7:0]         tag;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic write;
  } cell_ctl_t;

  // strict overlap, edges widened to 18 bits so sums cannot wrap
  function automatic logic overlap(entry_t a, entry_t b);
    logic signed [17:0] ax, ay, bx, by, axe, aye, bxe, bye;
    ax  = 18'(a.x);
    ay  = 18'(a.y);
    bx  = 18'(b.x);
    by  = 18'(b.y);
    axe = ax + $signed({3'b000, a.w});
    aye = ay + $signed({3'b000, a.h});
    bxe = bx + $signed({3'b000, b.w});
    bye = by + $signed({3'b000, b.h});
    return (ax < bxe) && (axe > bx) && (ay < bye) && (aye > by);
  endfunction

endpackage
`default_nettype wire

/* rtl/bct_in_if.sv */
// request channel of the box collision table
// no dependencies
`default_nettype none
interface bct_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [7:0]         entity_id;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [14:0]        box_width;
  logic [14:0]        box_height;

  modport source (output valid, action, entity_id, pos_x, pos_y, box_width, box_height,
                  input ready);
  modport sink (input valid, action, entity_id, pos_x, pos_y, box_width, box_height,
                output ready);
endinterface
`default_nettype wire

/* rtl/bct_out_if.sv */
// result channel of the box collision table
// no dependencies
`default_nettype none
interface bct_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       hit_valid;
  logic [7:0] hit_id;
  logic [5:0] hit_number;
  logic       last;

  modport source (output valid, status, hit_valid, hit_id, hit_number, last, input ready);
  modport sink (input valid, status, hit_valid, hit_id, hit_number, last, output ready);
endinterface
`default_nettype wire

/* rtl/box_collision_table.sv */
// box collision table: a row of CAPACITY cells that rotates through cell 0
// add, remove and other actions: one result, in the cycle after acceptance; remove compacts in that same cycle
// query: scans in S_SCAN, then gives its final result in S_FIN; no new request is taken before it returns to S_IDLE
// rotation pauses while the result register is stalled
// synchronous reset empties the table; slot contents are undefined until written
// uses bct_pkg, bct_in_if, bct_out_if, bct_cell, box_collision_table_defines.svh
`default_nettype none
`include "box_collision_table_defines.svh"
module box_collision_table #(
  parameter int CAPACITY = bct_pkg::CAPACITY_DEF
) (
  input wire logic clk,
  input wire logic rst,
  bct_in_if.sink   req,
  bct_out_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [5:0]    hits;
  bct_pkg::entry_t qbox;
  logic       pend_valid;
  logic [7:0] pend_id;
  logic [5:0] pend_num;

  logic       o_valid;
  logic [1:0] o_status;
  logic       o_hit_valid;
  logic [7:0] o_hit_id;
  logic [5:0] o_hit_number;
  logic       o_last;

  bct_pkg::entry_t   cells [CAPACITY];
  bct_pkg::cell_ctl_t ctl [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [CAPACITY:0]   prior_match;
  bct_pkg::entry_t   wr_data;

  logic ofree, accept, rotate, hit, found;

  assign ofree  = !o_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && ofree;
  assign accept = req.valid && req.ready;
  assign rotate = (state == S_SCAN) && (idx != CW'(CAPACITY)) && ofree;

  assign wr_data.tag = req.entity_id;
  assign wr_data.x   = req.pos_x;
  assign wr_data.y   = req.pos_y;
  assign wr_data.w   = req.box_width;
  assign wr_data.h   = req.box_height;

  // first-match chain for remove: cells from the match onward take their neighbour
  assign prior_match[0] = 1'b0;
  assign found = prior_match[CAPACITY];

  genvar k;
  generate
    for (k = 0; k < CAPACITY; k++) begin : g_cell
      assign match[k] = (cells[k].tag == req.entity_id) && (CW'(k) < count);
      assign prior_match[k+1] = prior_match[k] | match[k];
      assign ctl[k].write = accept && (req.action == bct_pkg::ACT_ADD) &&
                            (count == CW'(k));
      assign ctl[k].shift = rotate ||
                            (accept && (req.action == bct_pkg::ACT_REMOVE) &&
                             (prior_match[k] || match[k]));
      bct_cell u_cell (
        .clk       (clk),
        .ctl       (ctl[k]),
        .neighbour (cells[(k + 1) % CAPACITY]),
        .wr_data   (wr_data),
        .q         (cells[k])
      );
    end
  endgenerate

  assign hit = (idx < count) && (cells[0].tag != qbox.tag) &&
               bct_pkg::overlap(qbox, cells[0]) && (hits != 6'(bct_pkg::MAX_HITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      o_valid    <= 1'b0;
      pend_valid <= 1'b0;
      idx        <= '0;
      hits       <= '0;
    end else begin
      if (o_valid && rsp.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            o_hit_valid  <= 1'b0;
            o_hit_id     <= '0;
            o_hit_number <= '0;
            o_last       <= 1'b1;
            o_status     <= bct_pkg::ST_OK;
            unique case (req.action)
              bct_pkg::ACT_ADD: begin
                o_valid <= 1'b1;
                if (count >= CW'(CAPACITY)) begin
                  o_status <= bct_pkg::ST_FULL;
                end else begin
                  count <= count + 1'b1;
                end
              end
              bct_pkg::ACT_REMOVE: begin
                o_valid <= 1'b1;
                if (found) begin
                  count <= count - 1'b1;
                end else begin
                  o_status <= bct_pkg::ST_NOTFOUND;
                end
              end
              bct_pkg::ACT_QUERY: begin
                state      <= S_SCAN;
                idx        <= '0;
                hits       <= '0;
                pend_valid <= 1'b0;
                qbox       <= wr_data;
              end
              default: begin
                o_valid <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (idx == CW'(CAPACITY)) begin
            state <= S_FIN;
          end else if (ofree) begin
            idx <= idx + 1'b1;
            if (hit) begin
              hits       <= hits + 1'b1;
              pend_valid <= 1'b1;
              pend_id    <= cells[0].tag;
              pend_num   <= hits + 1'b1;
              // the previous hit is now known not to be the final one
              if (pend_valid) begin
                o_valid      <= 1'b1;
                o_status     <= bct_pkg::ST_OK;
                o_hit_valid  <= 1'b1;
                o_hit_id     <= pend_id;
                o_hit_number <= pend_num;
                o_last       <= 1'b0;
              end
            end
          end
        end
        S_FIN: begin
          if (ofree) begin
            o_valid      <= 1'b1;
            o_status     <= bct_pkg::ST_OK;
            o_hit_valid  <= pend_valid;
            o_hit_id     <= pend_valid ? pend_id : 8'd0;
            o_hit_number <= pend_valid ? pend_num : 6'd0;
            o_last       <= 1'b1;
            pend_valid   <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid      = o_valid;
  assign rsp.status     = o_status;
  assign rsp.hit_valid  = o_hit_valid;
  assign rsp.hit_id     = o_hit_id;
  assign rsp.hit_number = o_hit_number;
  assign rsp.last       = o_last;

  `BCT_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(CAPACITY))
  `BCT_ASSERT_IMP(a_hits_bound, clk, rst, 1'b1, hits <= 6'(bct_pkg::MAX_HITS))
  `BCT_ASSERT_IMP(a_idx_bound, clk, rst, state == S_SCAN, idx <= CW'(CAPACITY))
  `BCT_ASSERT_NXT(a_scan_holds_count, clk, rst, state == S_SCAN, count == $past(count))

endmodule
`default_nettype wire

/* rtl/bct_cell.sv */
// one table slot: holds a tagged box, loads new data or its neighbour's
// uses bct_pkg
`default_nettype none
module bct_cell (
  input  wire logic              clk,
  input  bct_pkg::cell_ctl_t     ctl,
  input  bct_pkg::entry_t        neighbour,
  input  bct_pkg::entry_t        wr_data,
  output bct_pkg::entry_t        q
);

  bct_pkg::entry_t entry;

  always_ff @(posedge clk) begin
    if (ctl.write) begin
      entry <= wr_data;
    end else if (ctl.shift) begin
      entry <= neighbour;
    end
  end

  assign q = entry;

endmodule
`default_nettype wire

/* sim/box_collision_table_test.sv */
// box collision table testbench: directed and random add, remove, query and other traffic
// predicts hits with its own table copy and checks every result transaction in order
// depends on bct_pkg, bct_in_if, bct_out_if and the box_collision_table rtl
`timescale 1ns / 100ps
`default_nettype none
module box_collision_table_test;

  localparam int TABLE_SIZE = 32;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [1:0] status;
    logic       hit_valid;
    logic [7:0] hit_id;
    logic [5:0] hit_number;
    logic       last;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bct_in_if  req ();
  bct_out_if rsp ();

  box_collision_table dut (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted table
  logic [7:0]         tbl_tag[TABLE_SIZE];
  logic signed [15:0] tbl_x[TABLE_SIZE];
  logic signed [15:0] tbl_y[TABLE_SIZE];
  logic [14:0]        tbl_w[TABLE_SIZE];
  logic [14:0]        tbl_h[TABLE_SIZE];
  int                 tbl_count = 0;

  result_t expected_results[$];
  int  failures = 0;
  int  idle_cycles = 0;
  bit  sender_idle_on = 1'b1;
  bit  receiver_idle_on = 1'b1;
  bit  long_hold_pending = 1'b0;
  int  hold_off = 0;

  initial begin
    req.valid = 1'b0;
    req.action = bct_pkg::ACT_ADD;
    req.entity_id = '0;
    req.pos_x = '0;
    req.pos_y = '0;
    req.box_width = '0;
    req.box_height = '0;
    rsp.ready = 1'b0;
  end

  function automatic void push_result(logic [1:0] st, logic hv, logic [7:0] id,
                                      logic [5:0] num, logic lst);
    result_t r;
    r.status = st;
    r.hit_valid = hv;
    r.hit_id = id;
    r.hit_number = num;
    r.last = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_transaction(logic [1:0] act, logic [7:0] id,
                                              logic signed [15:0] px, logic signed [15:0] py,
                                              logic [14:0] bw, logic [14:0] bh);
    int found;
    int hits;
    int first_hit;
    longint ax, ay, aw, ah, bx, by, bxe, bye;
    found = -1;
    hits = 0;
    first_hit = expected_results.size();
    if (act == bct_pkg::ACT_ADD) begin
      if (tbl_count >= TABLE_SIZE) begin
        push_result(bct_pkg::ST_FULL, 1'b0, 8'd0, 6'd0, 1'b1);
      end else begin
        tbl_tag[tbl_count] = id;
        tbl_x[tbl_count] = px;
        tbl_y[tbl_count] = py;
        tbl_w[tbl_count] = bw;
        tbl_h[tbl_count] = bh;
        tbl_count++;
        push_result(bct_pkg::ST_OK, 1'b0, 8'd0, 6'd0, 1'b1);
      end
    end else if (act == bct_pkg::ACT_REMOVE) begin
      for (int i = 0; i < tbl_count; i++) begin
        if (found < 0 && tbl_tag[i] == id) found = i;
      end
      if (found < 0) begin
        push_result(bct_pkg::ST_NOTFOUND, 1'b0, 8'd0, 6'd0, 1'b1);
      end else begin
        for (int i = found; i + 1 < tbl_count; i++) begin
          tbl_tag[i] = tbl_tag[i + 1];
          tbl_x[i] = tbl_x[i + 1];
          tbl_y[i] = tbl_y[i + 1];
          tbl_w[i] = tbl_w[i + 1];
          tbl_h[i] = tbl_h[i + 1];
        end
        tbl_count--;
        push_result(bct_pkg::ST_OK, 1'b0, 8'd0, 6'd0, 1'b1);
      end
    end else if (act == bct_pkg::ACT_QUERY) begin
      ax = px;
      ay = py;
      aw = longint'(bw);
      ah = longint'(bh);
      for (int i = 0; i < tbl_count && hits < bct_pkg::MAX_HITS; i++) begin
        bx = tbl_x[i];
        by = tbl_y[i];
        bxe = bx + longint'(tbl_w[i]);
        bye = by + longint'(tbl_h[i]);
        if (tbl_tag[i] != id && ax < bxe && ax + aw > bx &&
            ay < bye && ay + ah > by) begin
          hits++;
          push_result(bct_pkg::ST_OK, 1'b1, tbl_tag[i], 6'(hits), 1'b0);
        end
      end
      if (hits == 0) push_result(bct_pkg::ST_OK, 1'b0, 8'd0, 6'd0, 1'b1);
      else expected_results[first_hit + hits - 1].last = 1'b1;
    end else begin
      push_result(bct_pkg::ST_OK, 1'b0, 8'd0, 6'd0, 1'b1);
    end
  endfunction

  // one transaction on the request channel, with an occasional random gap in front
  task automatic send_item(logic [1:0] act, logic [7:0] id, logic signed [15:0] px,
                           logic signed [15:0] py, logic [14:0] bw, logic [14:0] bh);
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.action <= act;
    req.entity_id <= id;
    req.pos_x <= px;
    req.pos_y <= py;
    req.box_width <= bw;
    req.box_height <= bh;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_transaction(act, id, px, py, bw, bh);
  endtask

  task automatic stop_sending();
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    stop_sending();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // receiver: random stall bursts, or a counted hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp.ready <= 1'b0;
    end else if (long_hold_pending) begin
      long_hold_pending = 1'b0;
      hold_off <= 300;
      rsp.ready <= 1'b0;
    end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
      hold_off <= $urandom_range(0, 15);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got.status = rsp.status;
      got.hit_valid = rsp.hit_valid;
      got.hit_id = rsp.hit_id;
      got.hit_number = rsp.hit_number;
      got.last = rsp.last;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        if (got.hit_valid != want.hit_valid)
          $display("%0t: hit_valid expected %0d actual %0d", $time, want.hit_valid,
                   got.hit_valid);
        if (got.hit_id != want.hit_id)
          $display("%0t: hit_id expected %0d actual %0d", $time, want.hit_id, got.hit_id);
        if (got.hit_number != want.hit_number)
          $display("%0t: hit_number expected %0d actual %0d", $time, want.hit_number,
                   got.hit_number);
        if (got.last != want.last)
          $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
        if (got != want) failures++;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("box_collision_table_test NOT OK");
      $finish;
    end
  end

  function automatic logic [7:0] pick_tag();
    if (tbl_count > 0 && $urandom_range(0, 2) != 0)
      return tbl_tag[$urandom_range(0, tbl_count - 1)];
    return 8'($urandom_range(0, 15));
  endfunction

  // mostly small boxes in a narrow field so overlaps are common
  task automatic send_random(logic [1:0] act);
    logic signed [15:0] px, py;
    logic [14:0] bw, bh;
    if ($urandom_range(0, 9) == 0) begin
      px = 16'($urandom);
      py = 16'($urandom);
      bw = 15'($urandom);
      bh = 15'($urandom);
    end else begin
      px = 16'(int'($urandom_range(0, 400)) - 200);
      py = 16'(int'($urandom_range(0, 400)) - 200);
      bw = 15'($urandom_range(0, 200));
      bh = 15'($urandom_range(0, 200));
    end
    send_item(act, pick_tag(), px, py, bw, bh);
  endtask

  task automatic test_directed();
    send_item(bct_pkg::ACT_REMOVE, 8'd5, '0, '0, '0, '0);
    send_item(bct_pkg::ACT_QUERY, 8'd0, '0, '0, 15'h7fff, 15'h7fff);
    send_item(bct_pkg::ACT_ADD, 8'd1, 16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff);
    send_item(bct_pkg::ACT_ADD, 8'd255, 16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff);
    send_item(bct_pkg::ACT_ADD, 8'd2, 16'sd0, 16'sd0, 15'd16, 15'd16);
    send_item(bct_pkg::ACT_ADD, 8'd2, 16'sd8, 16'sd8, 15'd16, 15'd16);
    // edge contact with the first tag 2 box, overlap with the second
    send_item(bct_pkg::ACT_QUERY, 8'd9, 16'sd16, 16'sd0, 15'd16, 15'd16);
    send_item(bct_pkg::ACT_QUERY, 8'd9, 16'sd15, 16'sd15, 15'd1, 15'd1);
    // self tag skipped
    send_item(bct_pkg::ACT_QUERY, 8'd2, 16'sd0, 16'sd0, 15'd32, 15'd32);
    send_item(bct_pkg::ACT_QUERY, 8'd0, 16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff);
    send_item(bct_pkg::ACT_QUERY, 8'd0, 16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff);
    send_item(bct_pkg::ACT_QUERY, 8'd0, 16'sd4, 16'sd4, 15'd0, 15'd0);
    send_item(2'd3, 8'd2, 16'sd0, 16'sd0, 15'd1, 15'd1);
    send_item(bct_pkg::ACT_REMOVE, 8'd2, '0, '0, '0, '0);
    send_item(bct_pkg::ACT_REMOVE, 8'd77, '0, '0, '0, '0);
    send_item(bct_pkg::ACT_QUERY, 8'd0, 16'sd0, 16'sd0, 15'd32, 15'd32);
    drain();
  endtask

  // fill to capacity, overflow, then a query that hits every entry this test added
  task automatic test_full_table();
    while (tbl_count < TABLE_SIZE)
      send_item(bct_pkg::ACT_ADD, 8'(tbl_count + 10), 16'sd0, 16'sd0, 15'd100, 15'd100);
    send_item(bct_pkg::ACT_ADD, 8'd200, '0, '0, '0, '0);
    send_item(bct_pkg::ACT_QUERY, 8'd250, 16'sd50, 16'sd50, 15'd10, 15'd10);
    drain();
  endtask

  // long receiver hold-off while queries keep coming
  task automatic test_backpressure();
    receiver_idle_on = 1'b0;
    @(posedge clk);
    long_hold_pending = 1'b1;
    for (int i = 0; i < 12; i++) send_random(bct_pkg::ACT_QUERY);
    drain();
    receiver_idle_on = 1'b1;
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r < 8 && tbl_count < TABLE_SIZE - 2) send_random(bct_pkg::ACT_ADD);
      else if (r < 8 || r < 12) send_random(bct_pkg::ACT_REMOVE);
      else if (r < 19) send_random(bct_pkg::ACT_QUERY);
      else send_random(2'd3);
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    while (tbl_count > 0) send_item(bct_pkg::ACT_REMOVE,
                                    tbl_tag[$urandom_range(0, tbl_count - 1)],
                                    '0, '0, '0, '0);
    drain();
    test_backpressure();
    test_random(330);
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    test_random(60);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("box_collision_table_test OK");
    end else begin
      $display("box_collision_table_test NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/bct_pkg.sv
rtl/bct_in_if.sv
rtl/bct_out_if.sv
rtl/bct_cell.sv
rtl/box_collision_table.sv
sim/box_collision_table_test.sv
